### rtl/lppg_pkg.sv
// Shared types and constants for the LED pattern pixel generator.
package lppg_pkg;

  // Pattern modes
  localparam logic [1:0] MODE_SOLID   = 2'd0;
  localparam logic [1:0] MODE_STRIPE  = 2'd1;
  localparam logic [1:0] MODE_RAINBOW = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PATTERN_MODE      = 3'd0,
    CFG_LAYOUT_SERPENTINE = 3'd1,
    CFG_COLOR_A           = 3'd2,
    CFG_COLOR_B           = 3'd3,
    CFG_STRIPE_LEN        = 3'd4,
    CFG_CYCLE_LIMIT       = 3'd5
  } cfg_idx_t;

  localparam int CFG_DATA_W = 24;

  typedef struct packed {
    logic [1:0]  pattern_mode;
    logic        layout_serpentine;
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [7:0]  stripe_len;
    logic [15:0] cycle_limit;
  } cfg_t;

  // Work class decided by the front end
  typedef enum logic [2:0] {
    KIND_SOLID  = 3'd0,
    KIND_STRIPE = 3'd1,
    KIND_SPIRAL = 3'd2,
    KIND_SERP   = 3'd3,
    KIND_BLACK  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] led_addr;
    logic       frame_end;
    logic       restart;
    kind_t      kind;
  } item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Divider: 8-bit LED index over a 9-bit stripe period (2*255 at most)
  localparam int DIV_N      = 8;
  localparam int DIV_W      = 9;
  localparam int DIV_STEPS  = DIV_N / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  // Color wheel segment bounds
  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;
  localparam logic [7:0] WHEEL_MAX  = 8'd255;

endpackage

### rtl/lppg_fifo.sv
// Two-entry request queue between the front end and the back end.
module lppg_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lppg_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output lppg_pkg::item_t pop_item,
  output logic            empty
);
  import lppg_pkg::*;

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/lppg_front.sv
// Front end: takes requests and sorts them by the work they need.
module lppg_front (
  input  lppg_pkg::cfg_t  cfg,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic [7:0]      led_addr,
  input  logic            frame_end,
  input  logic            restart,
  input  logic            full,
  output logic            push,
  output lppg_pkg::item_t push_item
);
  import lppg_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (cfg.pattern_mode)
      MODE_SOLID:   kind = KIND_SOLID;
      MODE_STRIPE:  kind = KIND_STRIPE;
      MODE_RAINBOW: kind = cfg.layout_serpentine ? KIND_SERP : KIND_SPIRAL;
      default:      kind = KIND_BLACK;
    endcase
  end

  assign req_stall = full;
  assign push      = req_valid && !full;

  always_comb begin
    push_item.led_addr  = led_addr;
    push_item.frame_end = frame_end;
    push_item.restart   = restart;
    push_item.kind      = kind;
  end

endmodule

### rtl/lppg_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
module lppg_div (
  input  logic               clk,
  input  logic               rst,
  input  lppg_pkg::div_req_t req,
  output lppg_pkg::div_rsp_t rsp
);
  import lppg_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_N-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       s1;
  logic [DIV_W:0]       s2;
  logic                 last;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                              input logic             b,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, DIV_W'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[DIV_W-1:0]};
    end
  endfunction

  assign s1   = div_step(rem, quo[DIV_N-1], dvs);
  assign s2   = div_step(s1[DIV_W-1:0], quo[DIV_N-2], dvs);
  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      busy <= !last;
      done <= last;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N-3:0], s1[DIV_W], s2[DIV_W]};
      rem <= s2[DIV_W-1:0];
    end
  end

  always_comb begin
    rsp.busy      = busy;
    rsp.done      = done;
    rsp.remainder = rem;
  end

endmodule

### rtl/lppg_back.sv
// Back end: stripe modulo, hue counter, color wheel, result register.
module lppg_back #(
  parameter int LED_COUNT    = 256,
  parameter int STRIP_LENGTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lppg_pkg::cfg_t     cfg,
  input  logic               empty,
  input  lppg_pkg::item_t    head,
  output logic               pop,
  output lppg_pkg::div_req_t div_req,
  input  lppg_pkg::div_rsp_t div_rsp,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         pixel_position
);
  import lppg_pkg::*;

  localparam int POS_LUT_W = 256 * 8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state, state_next;
  logic [15:0] cnt, cnt_next;
  logic [7:0]  led_addr, led_addr_next;
  logic        frame_end, frame_end_next;
  logic [23:0] color, color_next;
  logic        use_wheel, use_wheel_next;
  logic [7:0]  hue, hue_next;

  logic        out_free;
  logic        load;
  logic        head_rainbow;
  logic [15:0] cnt_start;
  logic [7:0]  w_eff;
  logic [23:0] wheel_rgb;

  // Rainbow position for every 8-bit index, built at elaboration.
  // Serpentine: odd strips run backwards.
  function automatic logic [POS_LUT_W-1:0] pos_lut(input logic serp);
    logic [POS_LUT_W-1:0] lut;
    int                   strip;
    int                   off;
    int                   lg;
    lut = '0;
    for (int i = 0; i < 256; i++) begin
      if (serp) begin
        strip = i / STRIP_LENGTH;
        off   = i % STRIP_LENGTH;
        lg    = ((strip % 2) != 0) ? (STRIP_LENGTH - 1 - off) : off;
        lut[i*8 +: 8] = 8'((lg * 256) / STRIP_LENGTH);
      end else begin
        lut[i*8 +: 8] = 8'((i * 256) / LED_COUNT);
      end
    end
    return lut;
  endfunction

  localparam logic [POS_LUT_W-1:0] SPIRAL_LUT = pos_lut(1'b0);
  localparam logic [POS_LUT_W-1:0] SERP_LUT   = pos_lut(1'b1);

  function automatic logic [23:0] wheel(input logic [7:0] h);
    logic [7:0] p;
    logic [7:0] up;
    if (h < WHEEL_SEG1) begin
      p  = h;
      up = 8'({p, 1'b0} + {1'b0, p});
      wheel = {up, WHEEL_MAX - up, 8'd0};
    end else if (h < WHEEL_SEG2) begin
      p  = h - WHEEL_SEG1;
      up = 8'({p, 1'b0} + {1'b0, p});
      wheel = {WHEEL_MAX - up, 8'd0, up};
    end else begin
      p  = h - WHEEL_SEG2;
      up = 8'({p, 1'b0} + {1'b0, p});
      wheel = {8'd0, up, WHEEL_MAX - up};
    end
  endfunction

  assign out_free     = !res_valid || !res_stall;
  assign w_eff        = (cfg.stripe_len == 8'd0) ? 8'd1 : cfg.stripe_len;
  assign head_rainbow = (head.kind == KIND_SPIRAL) || (head.kind == KIND_SERP);
  assign wheel_rgb    = wheel(hue);

  // restart clears first, then a rainbow pixel wraps the counter at the limit
  always_comb begin
    cnt_start = head.restart ? 16'd0 : cnt;
    if (head_rainbow && (cnt_start >= cfg.cycle_limit)) begin
      cnt_start = 16'd0;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    led_addr_next  = led_addr;
    frame_end_next = frame_end;
    color_next     = color;
    use_wheel_next = use_wheel;
    hue_next       = hue;
    pop            = 1'b0;
    load           = 1'b0;
    div_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          pop            = 1'b1;
          cnt_next       = cnt_start;
          led_addr_next  = head.led_addr;
          frame_end_next = head.frame_end;
          use_wheel_next = 1'b0;
          case (head.kind)
            KIND_SOLID: begin
              color_next = cfg.color_a;
              state_next = S_DONE;
            end
            KIND_STRIPE: begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_N'(head.led_addr);
              div_req.divisor  = DIV_W'({w_eff, 1'b0});
              state_next       = S_DIV;
            end
            KIND_SPIRAL: begin
              hue_next       = SPIRAL_LUT[{head.led_addr, 3'b000} +: 8] + cnt_start[7:0];
              use_wheel_next = 1'b1;
              state_next     = S_DONE;
            end
            KIND_SERP: begin
              hue_next       = SERP_LUT[{head.led_addr, 3'b000} +: 8] + cnt_start[7:0];
              use_wheel_next = 1'b1;
              state_next     = S_DONE;
            end
            default: begin
              color_next = 24'd0;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          color_next = (div_rsp.remainder < DIV_W'(w_eff)) ? cfg.color_a : cfg.color_b;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          if (use_wheel && frame_end) begin
            cnt_next = cnt + 16'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 16'd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    led_addr  <= led_addr_next;
    frame_end <= frame_end_next;
    color     <= color_next;
    use_wheel <= use_wheel_next;
    hue       <= hue_next;
    if (load) begin
      {red, green, blue} <= use_wheel ? wheel_rgb : color;
      pixel_position     <= led_addr;
    end
  end

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished with no division pending");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_cnt_wrapped: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && use_wheel) |-> (cnt < cfg.cycle_limit || cnt == 16'd0))
    else $error("hue counter not wrapped before rendering");

endmodule

### rtl/led_pattern_pixel_generator_top.sv
// Top level of the LED pattern pixel generator: config registers and block wiring.
// Path, accept to result valid: queue, back end state machine, result register; stripes
//   also wait on the radix-4 divider for the modulo; result stalls add to both.
// The back end works on one request at a time behind a two-entry queue.
// Reset (rst, sync, active high): queue and result empty, hue counter 0, registers default.
module led_pattern_pixel_generator_top #(
  parameter int LED_COUNT    = 256,
  parameter int STRIP_LENGTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [lppg_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [7:0]                      led_addr,
  input  logic                            frame_end,
  input  logic                            restart,
  // result channel
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [7:0]                      pixel_position
);
  import lppg_pkg::*;

  cfg_t     cfg;
  logic     full;
  logic     empty;
  logic     push;
  logic     pop;
  item_t    push_item;
  item_t    head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register file; the user must write only while the block is idle, which the block
  // itself does not enforce, and the back end reads these live.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_mode      <= MODE_SOLID;
      cfg.layout_serpentine <= 1'b0;
      cfg.color_a           <= 24'd0;
      cfg.color_b           <= 24'd0;
      cfg.stripe_len        <= 8'd4;
      cfg.cycle_limit       <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_MODE:      cfg.pattern_mode      <= cfg_data[1:0];
        CFG_LAYOUT_SERPENTINE: cfg.layout_serpentine <= cfg_data[0];
        CFG_COLOR_A:           cfg.color_a           <= cfg_data[23:0];
        CFG_COLOR_B:           cfg.color_b           <= cfg_data[23:0];
        CFG_STRIPE_LEN:        cfg.stripe_len        <= cfg_data[7:0];
        CFG_CYCLE_LIMIT:       cfg.cycle_limit       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify by mode and layout
  lppg_front u_front (
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .led_addr  (led_addr),
    .frame_end (frame_end),
    .restart   (restart),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  lppg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (head),
    .empty     (empty)
  );

  // Divider for the stripe modulo
  lppg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Back end: hue counter, color wheel, result register
  lppg_back #(
    .LED_COUNT    (LED_COUNT),
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .pixel_position (pixel_position)
  );

endmodule

### test/lppg_pixel_checker.sv
// Checker for the LED pattern pixel generator: mirrors registers, predicts pixels, compares.
`timescale 1ns / 100ps

module lppg_pixel_checker #(
  parameter int LED_COUNT    = 256,
  parameter int STRIP_LENGTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [lppg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic [7:0]                      led_addr,
  input  logic                            frame_end,
  input  logic                            restart,
  input  logic                            res_valid,
  input  logic                            res_stall,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic [7:0]                      pixel_position,
  output int                              fail_count,
  output int                              pending
);
  import lppg_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pos;
  } pixel_t;

  // shadow registers and hue counter
  logic [1:0]  mode_q;
  logic        serp_q;
  logic [23:0] color_a_q;
  logic [23:0] color_b_q;
  logic [7:0]  stripe_q;
  logic [15:0] limit_q;
  logic [15:0] hue_count;

  pixel_t expected_pixels[$];
  int     errors_seen = 0;

  function automatic pixel_t render_pixel(logic [7:0] idx, logic fe, logic rs);
    pixel_t      px;
    logic [23:0] c;
    int unsigned w, p, strip, off, lg;
    logic [7:0]  pos, seg;
    px     = '0;
    px.pos = idx;
    if (rs) hue_count = '0;
    case (mode_q)
      MODE_SOLID: begin
        px.red   = color_a_q[23:16];
        px.green = color_a_q[15:8];
        px.blue  = color_a_q[7:0];
      end
      MODE_STRIPE: begin
        w = (stripe_q == 8'd0) ? 1 : stripe_q;
        c = ((idx % (2 * w)) < w) ? color_a_q : color_b_q;
        px.red   = c[23:16];
        px.green = c[15:8];
        px.blue  = c[7:0];
      end
      MODE_RAINBOW: begin
        if (hue_count >= limit_q) hue_count = '0;
        if (!serp_q) begin
          p = ((int'(idx) * 256) / LED_COUNT) % 256;
        end else begin
          strip = idx / STRIP_LENGTH;
          off   = idx % STRIP_LENGTH;
          lg    = strip[0] ? (STRIP_LENGTH - 1 - off) : off;
          p     = ((lg * 256) / STRIP_LENGTH) % 256;
        end
        pos = 8'(p + hue_count);
        if (pos < WHEEL_SEG1) begin
          px.red   = 8'(pos * 3);
          px.green = WHEEL_MAX - 8'(pos * 3);
          px.blue  = '0;
        end else if (pos < WHEEL_SEG2) begin
          seg      = pos - WHEEL_SEG1;
          px.red   = WHEEL_MAX - 8'(seg * 3);
          px.green = '0;
          px.blue  = 8'(seg * 3);
        end else begin
          seg      = pos - WHEEL_SEG2;
          px.red   = '0;
          px.green = 8'(seg * 3);
          px.blue  = WHEEL_MAX - 8'(seg * 3);
        end
        if (fe) hue_count = hue_count + 16'd1;
      end
      default: ;  // unused mode: black
    endcase
    return px;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      mode_q    = MODE_SOLID;
      serp_q    = 1'b0;
      color_a_q = '0;
      color_b_q = '0;
      stripe_q  = 8'd4;
      limit_q   = 16'd256;
      hue_count = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_MODE:      mode_q    = cfg_data[1:0];
          CFG_LAYOUT_SERPENTINE: serp_q    = cfg_data[0];
          CFG_COLOR_A:           color_a_q = cfg_data[23:0];
          CFG_COLOR_B:           color_b_q = cfg_data[23:0];
          CFG_STRIPE_LEN:        stripe_q  = cfg_data[7:0];
          CFG_CYCLE_LIMIT:       limit_q   = cfg_data[15:0];
          default: ;
        endcase
      end
      // result first: a request taken on this edge cannot be answered on it
      if (res_valid && !res_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: position %0d", pixel_position);
          errors_seen++;
        end else begin
          want = expected_pixels.pop_front();
          if (red !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, red);
            errors_seen++;
          end
          if (green !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, green);
            errors_seen++;
          end
          if (blue !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, blue);
            errors_seen++;
          end
          if (pixel_position !== want.pos) begin
            $error("pixel_position mismatch: expected %0d, actual %0d",
                   want.pos, pixel_position);
            errors_seen++;
          end
        end
      end
      if (req_valid && !req_stall)
        expected_pixels.push_back(render_pixel(led_addr, frame_end, restart));
    end
    pending    <= expected_pixels.size();
    fail_count <= errors_seen;
  end

endmodule

### test/tb_led_pattern_pixel_generator_top.sv
// Testbench top for the LED pattern pixel generator: stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module tb_led_pattern_pixel_generator_top;
  import lppg_pkg::*;

  localparam int LED_COUNT    = 256;
  localparam int STRIP_LENGTH = 32;

  localparam logic [1:0] MODE_UNUSED = 2'd3;   // decodes to black
  localparam logic [2:0] CFG_UNUSED  = 3'd7;   // no register behind it

  localparam int NUM_PHASES  = 28;
  localparam int IDLE_GUARD  = 30;      // slack before touching registers
  localparam int END_DRAIN   = 40;
  localparam int HOLD_FIRST  = 1500;    // first long receiver hold-off
  localparam int HOLD_PERIOD = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int RUN_LIMIT   = 800000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [7:0]            led_addr = '0;
  logic                  frame_end = 1'b0;
  logic                  restart = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [7:0]            pixel_position;

  int fail_count;
  int pending;

  // sender burst state
  int burst_left = 0;
  bit sender_gaps_on = 1'b1;

  led_pattern_pixel_generator_top #(
    .LED_COUNT   (LED_COUNT),
    .STRIP_LENGTH(STRIP_LENGTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .led_addr      (led_addr),
    .frame_end     (frame_end),
    .restart       (restart),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .pixel_position(pixel_position)
  );

  lppg_pixel_checker #(
    .LED_COUNT   (LED_COUNT),
    .STRIP_LENGTH(STRIP_LENGTH)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .led_addr      (led_addr),
    .frame_end     (frame_end),
    .restart       (restart),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .pixel_position(pixel_position),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One register write; the strobe drops on the following edge.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one pixel request and hold it until taken. A new burst may open
  // with a gap; within a burst valid stays high from request to request.
  task automatic send_pixel(input logic [7:0] idx, input logic fe, input logic rs);
    int gap;
    int roll;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = 0;
      if (sender_gaps_on) begin
        roll = $urandom_range(0, 9);
        if (roll < 6)      gap = $urandom_range(0, 2);
        else if (roll < 9) gap = $urandom_range(3, 25);
        else               gap = $urandom_range(26, 60);
      end
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    led_addr  <= idx;
    frame_end <= fe;
    restart   <= rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted pixel has come back,
  // then give the pipeline a little slack before touching registers.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 4))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Main stimulus: directed corners first, then random phases, each with a
  // fresh register setting written while the block sits idle.
  initial begin : stimulus
    int          phase;
    int          sent;
    int          target;
    int          len;
    int          k;
    logic [7:0]  start_idx;
    bit          rs_first;
    logic [1:0]  mode_sel;
    logic [7:0]  stripe_sel;
    logic [15:0] limit_sel;

    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: solid black
    send_pixel(8'd0, 1'b0, 1'b0);

    // solid white; counter controls must not matter outside rainbow
    wait_idle();
    write_reg(CFG_PATTERN_MODE, 24'(MODE_SOLID));
    write_reg(CFG_COLOR_A, 24'hFFFFFF);
    write_reg(CFG_UNUSED, 24'($urandom));
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b1);

    // stripes, zero width behaves as width one
    wait_idle();
    write_reg(CFG_PATTERN_MODE, 24'(MODE_STRIPE));
    write_reg(CFG_STRIPE_LEN, 24'd0);
    write_reg(CFG_COLOR_A, 24'hA5C33C);
    write_reg(CFG_COLOR_B, 24'h5A3CC3);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd1, 1'b0, 1'b0);
    send_pixel(8'd2, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);

    // widest stripe: 254 still color A, 255 turns to color B, no index reaches 2*255
    wait_idle();
    write_reg(CFG_STRIPE_LEN, 24'd255);
    send_pixel(8'd254, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);

    // unused mode gives black
    wait_idle();
    write_reg(CFG_PATTERN_MODE, 24'(MODE_UNUSED));
    send_pixel(8'd7, 1'b1, 1'b1);

    // rainbow with zero cycle limit: counter always reads zero
    wait_idle();
    write_reg(CFG_PATTERN_MODE, 24'(MODE_RAINBOW));
    write_reg(CFG_LAYOUT_SERPENTINE, 24'd0);
    write_reg(CFG_CYCLE_LIMIT, 24'd0);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd128, 1'b1, 1'b0);

    // small limit: counter wraps, then wheel segment edges from a restart
    wait_idle();
    write_reg(CFG_CYCLE_LIMIT, 24'd3);
    send_pixel(8'd0, 1'b1, 1'b1);
    send_pixel(8'd10, 1'b1, 1'b0);
    send_pixel(8'd20, 1'b1, 1'b0);
    send_pixel(8'd30, 1'b1, 1'b0);
    send_pixel(8'd84, 1'b0, 1'b1);
    send_pixel(8'd85, 1'b0, 1'b0);
    send_pixel(8'd169, 1'b0, 1'b0);
    send_pixel(8'd170, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);

    // serpentine strip edges and an index in the last strip
    wait_idle();
    write_reg(CFG_LAYOUT_SERPENTINE, 24'd1);
    write_reg(CFG_CYCLE_LIMIT, 24'hFFFF);
    send_pixel(8'd0, 1'b0, 1'b1);
    send_pixel(8'd31, 1'b0, 1'b0);
    send_pixel(8'd32, 1'b0, 1'b0);
    send_pixel(8'd63, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);

    // random phases
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0, 1:    mode_sel = MODE_SOLID;
        2, 3:    mode_sel = MODE_STRIPE;
        4:       mode_sel = MODE_UNUSED;
        default: mode_sel = MODE_RAINBOW;
      endcase
      case ($urandom_range(0, 5))
        0:       stripe_sel = 8'd0;
        1:       stripe_sel = 8'd1;
        2:       stripe_sel = 8'd255;
        3, 4:    stripe_sel = 8'($urandom_range(2, 12));
        default: stripe_sel = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 6))
        0:       limit_sel = 16'd0;
        1:       limit_sel = 16'd1;
        2:       limit_sel = 16'hFFFF;
        3:       limit_sel = 16'd256;
        4, 5:    limit_sel = 16'($urandom_range(2, 12));
        default: limit_sel = 16'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_PATTERN_MODE, 24'(mode_sel));
      write_reg(CFG_LAYOUT_SERPENTINE, 24'($urandom_range(0, 1)));
      write_reg(CFG_COLOR_A, pick_color());
      write_reg(CFG_COLOR_B, pick_color());
      write_reg(CFG_STRIPE_LEN, 24'(stripe_sel));
      write_reg(CFG_CYCLE_LIMIT, 24'(limit_sel));

      // some phases run back to back with no sender gaps
      sender_gaps_on = ($urandom_range(0, 4) != 0);
      sent   = 0;
      target = $urandom_range(25, 45);
      while (sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          // a frame: consecutive LEDs, counter advanced on the last one
          len       = $urandom_range(4, 40);
          start_idx = 8'($urandom);
          rs_first  = ($urandom_range(0, 3) == 0);
          for (k = 0; k < len; k++)
            send_pixel(8'(start_idx + k), (k == len - 1), (k == 0) && rs_first);
          sent += len;
        end else begin
          // stray request with random controls
          send_pixel(8'($urandom), ($urandom_range(0, 2) == 0),
                     ($urandom_range(0, 9) == 0));
          sent++;
        end
      end
    end

    // drain, then verdict
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("led_pattern_pixel_generator_top test passed");
    end else begin
      $display("led_pattern_pixel_generator_top test failed");
    end
    $finish;
  end

  // Receiver: stall pattern of its own, changing style every stretch, with a
  // long hold-off now and then so the request queue fills and backs up.
  initial begin : rx_pattern
    int style;
    int span;
    int rx_cycles;
    int next_hold;
    rx_cycles = 0;
    next_hold = HOLD_FIRST;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_cycles >= next_hold) begin
        repeat (LONG_HOLD) begin
          res_stall <= 1'b1;
          @(posedge clk);
          rx_cycles++;
        end
        next_hold += HOLD_PERIOD;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(8, 150);
        repeat (span) begin
          case (style)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= 1'($urandom_range(0, 1));
            default: res_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
          rx_cycles++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("led_pattern_pixel_generator_top test failed");
    $finish;
  end

endmodule
